[sv/mlpbp_pkg.sv]
// Shared types, constants and the sigmoid table function for the MLP trainer.
package mlpbp_pkg;

  localparam int HIDDEN_DEF = 4;
  localparam int SIG_ENTRIES_DEF = 256;
  localparam logic [12:0] RATE_RESET = 13'd410;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint INV_E_Q30 = 64'sd395007542;

  localparam logic [1:0] OPER_LOAD = 2'd0;
  localparam logic [1:0] OPER_TRAIN = 2'd1;

  // datapath commands
  typedef enum logic [4:0] {
    DP_NONE, DP_LOAD, DP_MAC, DP_HIDX, DP_ROM, DP_HSTORE, DP_OIDX, DP_OSTORE,
    DP_P_O, DP_DOUT, DP_ERR, DP_P_H, DP_DH, DP_Q_H, DP_UPD_H, DP_Q_O, DP_UPD_O,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] j;
    logic [1:0] i;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // Quotient of two non-negative values by shift and subtract; table build only.
  function automatic longint udiv_q(input longint num, input longint den);
    longint quo, rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 1;
      end
    end
    return quo;
  endfunction

  // Sigmoid of the bucket midpoint, Q1.12, from a floored Taylor series in Q.30.
  function automatic logic [12:0] sig_entry(input int idx, input int entries);
    longint x, a, n, f, term, sum, d, p;
    x = -64'sd32768 + udiv_q((2 * longint'(idx) + 1) * 32768, longint'(entries));
    a = (x < 0) ? -x : x;
    n = a >>> 12;
    f = a & 4095;
    term = ONE_Q30;
    sum = ONE_Q30;
    for (int k = 1; k <= 16; k++) begin
      term = udiv_q(term * f, 4096 * longint'(k));
      sum = ((k & 1) == 1) ? sum - term : sum + term;
    end
    for (longint m = 0; m < n; m++) begin
      sum = (sum * INV_E_Q30) >>> 30;
    end
    d = ONE_Q30 + sum;
    p = udiv_q((64'sd1 <<< 42) + (d >>> 1), d);
    if (x < 0) begin
      p = 4096 - p;
    end
    return p[12:0];
  endfunction

endpackage

[sv/mlpbp_ctrl.sv]
// Sequencer for load, forward pass and weight update of the MLP trainer.
module mlpbp_ctrl #(
  parameter int HIDDEN = mlpbp_pkg::HIDDEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_oper,
  output logic             in_ready,
  input  mlpbp_pkg::sts_t  sts,
  output mlpbp_pkg::cmd_t  cmd
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'd1 << 0,
    S_LOAD   = 19'd1 << 1,
    S_HMAC   = 19'd1 << 2,
    S_HIDX   = 19'd1 << 3,
    S_HROM   = 19'd1 << 4,
    S_HSTORE = 19'd1 << 5,
    S_OIDX   = 19'd1 << 6,
    S_OROM   = 19'd1 << 7,
    S_OSTORE = 19'd1 << 8,
    S_D1     = 19'd1 << 9,
    S_D2     = 19'd1 << 10,
    S_E1     = 19'd1 << 11,
    S_E2     = 19'd1 << 12,
    S_E3     = 19'd1 << 13,
    S_E4     = 19'd1 << 14,
    S_UH     = 19'd1 << 15,
    S_Q1     = 19'd1 << 16,
    S_UO     = 19'd1 << 17,
    S_DONE   = 19'd1 << 18
  } state_t;

  localparam logic [3:0] JLAST = 4'(HIDDEN - 1);

  state_t     state, state_next;
  logic [3:0] j, j_next;
  logic [1:0] i, i_next;
  logic       train, train_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    j_next = j;
    i_next = i;
    train_next = train;
    cmd.op = mlpbp_pkg::DP_NONE;
    cmd.j = j;
    cmd.i = i;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          train_next = (in_oper == mlpbp_pkg::OPER_TRAIN);
          j_next = '0;
          i_next = '0;
          state_next = (in_oper == mlpbp_pkg::OPER_LOAD) ? S_LOAD : S_HMAC;
        end
      end
      S_LOAD: begin
        cmd.op = mlpbp_pkg::DP_LOAD;
        state_next = S_DONE;
      end
      S_HMAC: begin
        cmd.op = mlpbp_pkg::DP_MAC;
        if (i == 2'd2) begin
          i_next = '0;
          state_next = S_HIDX;
        end else begin
          i_next = i + 2'd1;
        end
      end
      S_HIDX: begin
        cmd.op = mlpbp_pkg::DP_HIDX;
        state_next = S_HROM;
      end
      S_HROM: begin
        cmd.op = mlpbp_pkg::DP_ROM;
        state_next = S_HSTORE;
      end
      S_HSTORE: begin
        cmd.op = mlpbp_pkg::DP_HSTORE;
        if (j == JLAST) begin
          j_next = '0;
          state_next = S_OIDX;
        end else begin
          j_next = j + 4'd1;
          state_next = S_HMAC;
        end
      end
      S_OIDX: begin
        cmd.op = mlpbp_pkg::DP_OIDX;
        state_next = S_OROM;
      end
      S_OROM: begin
        cmd.op = mlpbp_pkg::DP_ROM;
        state_next = S_OSTORE;
      end
      S_OSTORE: begin
        cmd.op = mlpbp_pkg::DP_OSTORE;
        state_next = train ? S_D1 : S_DONE;
      end
      S_D1: begin
        cmd.op = mlpbp_pkg::DP_P_O;
        state_next = S_D2;
      end
      S_D2: begin
        cmd.op = mlpbp_pkg::DP_DOUT;
        j_next = '0;
        state_next = S_E1;
      end
      S_E1: begin
        cmd.op = mlpbp_pkg::DP_ERR;
        state_next = S_E2;
      end
      S_E2: begin
        cmd.op = mlpbp_pkg::DP_P_H;
        state_next = S_E3;
      end
      S_E3: begin
        cmd.op = mlpbp_pkg::DP_DH;
        state_next = S_E4;
      end
      S_E4: begin
        cmd.op = mlpbp_pkg::DP_Q_H;
        i_next = '0;
        state_next = S_UH;
      end
      S_UH: begin
        cmd.op = mlpbp_pkg::DP_UPD_H;
        if (i == 2'd2) begin
          i_next = '0;
          if (j == JLAST) begin
            j_next = '0;
            state_next = S_Q1;
          end else begin
            j_next = j + 4'd1;
            state_next = S_E1;
          end
        end else begin
          i_next = i + 2'd1;
        end
      end
      S_Q1: begin
        cmd.op = mlpbp_pkg::DP_Q_O;
        state_next = S_UO;
      end
      S_UO: begin
        cmd.op = mlpbp_pkg::DP_UPD_O;
        if (j == JLAST) begin
          state_next = S_DONE;
        end else begin
          j_next = j + 4'd1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op = mlpbp_pkg::DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j <= '0;
      i <= '0;
      train <= 1'b0;
    end else begin
      state <= state_next;
      j <= j_next;
      i <= i_next;
      train <= train_next;
    end
  end

endmodule

[sv/mlpbp_dp.sv]
// Weight store, multiply datapath, sigmoid table and result register.
module mlpbp_dp #(
  parameter int HIDDEN = mlpbp_pkg::HIDDEN_DEF,
  parameter int SIG_ENTRIES = mlpbp_pkg::SIG_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          in_oper,
  input  logic [5:0]          in_widx,
  input  logic signed [15:0]  in_wval,
  input  logic [12:0]         in_x0,
  input  logic [12:0]         in_x1,
  input  logic [12:0]         in_x2,
  input  logic [12:0]         in_goal,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_wdata,
  input  mlpbp_pkg::cmd_t     cmd,
  output mlpbp_pkg::sts_t     sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [12:0]         out_pred,
  output logic signed [13:0]  out_resid,
  output logic                out_status
);

  localparam int NHW = 3 * HIDDEN;
  localparam int HW_W = $clog2(NHW);
  localparam int JW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int IDXW = $clog2(SIG_ENTRIES);

  logic [12:0]        sig_tab [SIG_ENTRIES];
  logic signed [15:0] w_h [NHW];
  logic signed [15:0] w_o [HIDDEN];
  logic [12:0]        h [HIDDEN];

  logic [12:0]        x0, x1, x2, goal, rate;
  logic [5:0]         widx;
  logic signed [15:0] wval;
  logic               is_load, ld_bad;
  logic signed [35:0] acc, oacc;
  logic [IDXW-1:0]    idx;
  logic [12:0]        sig_q, o;
  logic signed [13:0] r;
  logic signed [24:0] p;
  logic signed [15:0] dout;
  logic signed [17:0] err;
  logic signed [15:0] dh;
  logic signed [31:0] q;

  logic [HW_W-1:0]    haddr;
  logic [JW-1:0]      jj;
  logic signed [13:0] xsel;
  logic [12:0]        hsel;
  logic signed [47:0] step_h, step_o;

  for (genvar g = 0; g < SIG_ENTRIES; g++) begin : g_tab
    assign sig_tab[g] = mlpbp_pkg::sig_entry(g, SIG_ENTRIES);
  end

  function automatic logic [IDXW-1:0] sig_index(input logic signed [35:0] s);
    logic signed [23:0] z;
    logic signed [24:0] t;
    logic [47:0]        prod;
    z = 24'(s >>> 12);
    t = 25'(z) + 25'sd32768;
    prod = 48'(t[15:0]) * 48'(SIG_ENTRIES);
    if (t < 0) begin
      return '0;
    end else if (t > 25'sd65535) begin
      return IDXW'(SIG_ENTRIES - 1);
    end else begin
      return prod[IDXW+15:16];
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  assign haddr = HW_W'(3 * int'(cmd.j) + int'(cmd.i));
  assign jj = JW'(cmd.j);
  assign hsel = h[jj];

  always_comb begin
    unique case (cmd.i)
      2'd0: xsel = {1'b0, x0};
      2'd1: xsel = {1'b0, x1};
      default: xsel = {1'b0, x2};
    endcase
  end

  assign step_h = (48'(q) * 48'(xsel)) >>> 24;
  assign step_o = (48'(q) * 48'($signed({1'b0, hsel}))) >>> 24;

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      x0 <= in_x0;
      x1 <= in_x1;
      x2 <= in_x2;
      goal <= in_goal;
      widx <= in_widx;
      wval <= in_wval;
      is_load <= (in_oper == mlpbp_pkg::OPER_LOAD);
      acc <= '0;
      oacc <= '0;
    end
    unique case (cmd.op)
      mlpbp_pkg::DP_LOAD: begin
        ld_bad <= 1'b0;
        if (int'(widx) < NHW) begin
          w_h[HW_W'(widx)] <= wval;
        end else if (int'(widx) < 4 * HIDDEN) begin
          w_o[JW'(int'(widx) - NHW)] <= wval;
        end else begin
          ld_bad <= 1'b1;
        end
      end
      mlpbp_pkg::DP_MAC: acc <= acc + 36'(w_h[haddr]) * 36'(xsel);
      mlpbp_pkg::DP_HIDX: idx <= sig_index(acc);
      mlpbp_pkg::DP_ROM: sig_q <= sig_tab[idx];
      mlpbp_pkg::DP_HSTORE: begin
        h[jj] <= sig_q;
        oacc <= oacc + 36'(w_o[jj]) * 36'($signed({1'b0, sig_q}));
        acc <= '0;
      end
      mlpbp_pkg::DP_OIDX: idx <= sig_index(oacc);
      mlpbp_pkg::DP_OSTORE: begin
        o <= sig_q;
        r <= $signed({1'b0, goal}) - $signed({1'b0, sig_q});
      end
      mlpbp_pkg::DP_P_O: p <= $signed({12'd0, o}) * $signed({12'd0, 13'd4096 - o});
      mlpbp_pkg::DP_DOUT: dout <= 16'((48'(p) * 48'(r)) >>> 24);
      mlpbp_pkg::DP_ERR: err <= 18'((48'(w_o[jj]) * 48'(dout)) >>> 12);
      mlpbp_pkg::DP_P_H: p <= $signed({12'd0, hsel}) * $signed({12'd0, 13'd4096 - hsel});
      mlpbp_pkg::DP_DH: dh <= 16'((48'(p) * 48'(err)) >>> 24);
      mlpbp_pkg::DP_Q_H: q <= 32'($signed({1'b0, rate})) * 32'(dh);
      mlpbp_pkg::DP_UPD_H: w_h[haddr] <= sat16(48'(w_h[haddr]) + step_h);
      mlpbp_pkg::DP_Q_O: q <= 32'($signed({1'b0, rate})) * 32'(dout);
      mlpbp_pkg::DP_UPD_O: w_o[jj] <= sat16(48'(w_o[jj]) + step_o);
      default: begin
      end
    endcase
  end

  // learning rate and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= mlpbp_pkg::RATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate <= cfg_wdata;
      end
      if (cmd.op == mlpbp_pkg::DP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mlpbp_pkg::DP_EMIT) begin
      out_pred <= is_load ? 13'd0 : o;
      out_resid <= is_load ? 14'sd0 : r;
      out_status <= is_load & ld_bad;
    end
  end

endmodule

[sv/mlp_online_backprop_step_top.sv]
// Top level of the online two-layer sigmoid MLP trainer.
// Input stream s_*: one transaction per item; s_tuser carries the operation
// (0 load weight, 1 train step, 2 or 3 infer). Output stream m_*: exactly one
// transaction per input item, carrying prediction and residual in m_tdata and
// the load status flag in m_tuser.
// Config channel cfg_*: writes the learning rate, ready except during reset;
// write it only while no item is in flight.
// Items are processed one at a time by a sequencer over the datapath.
// The time from acceptance to result valid is set by the per-neuron walks
// of the forward pass (3 MACs plus a registered table lookup) and the update.
// s_tready is high only while the sequencer is idle, so the next item can be
// taken at the earliest in the same cycle as the result goes valid.
// A finished result waits in the output register; if m_tready is low the
// sequencer holds there and takes no new item until the register frees.
// Reset (rst, synchronous) returns to idle, drops m_tvalid and sets the rate
// to 410; s_tready and cfg_ready are low while rst is high; weights are
// undefined until loaded.
module mlp_online_backprop_step_top #(
  parameter int HIDDEN = mlpbp_pkg::HIDDEN_DEF,
  parameter int SIG_ENTRIES = mlpbp_pkg::SIG_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [5:0] weight_index, [21:6] weight_value, [34:22] in_first,
  // [47:35] in_second, [60:48] in_third, [73:61] goal, [79:74] zero
  input  logic [79:0] s_tdata,
  // [1:0] operation
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [12:0] prediction, [26:13] residual, [31:27] zero
  output logic [31:0] m_tdata,
  // [0] status
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  mlpbp_pkg::cmd_t cmd;
  mlpbp_pkg::sts_t sts;
  logic [12:0]        pred;
  logic signed [13:0] resid;

  assign cfg_ready = !rst;

  mlpbp_ctrl #(.HIDDEN(HIDDEN)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_oper  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlpbp_dp #(.HIDDEN(HIDDEN), .SIG_ENTRIES(SIG_ENTRIES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_tvalid && s_tready),
    .in_oper    (s_tuser),
    .in_widx    (s_tdata[5:0]),
    .in_wval    (s_tdata[21:6]),
    .in_x0      (s_tdata[34:22]),
    .in_x1      (s_tdata[47:35]),
    .in_x2      (s_tdata[60:48]),
    .in_goal    (s_tdata[73:61]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_wdata  (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_pred   (pred),
    .out_resid  (resid),
    .out_status (m_tuser)
  );

  assign m_tdata = {5'd0, resid, pred};

endmodule

[sv/mlpbp_chk.sv]
// Port-level checker for the MLP trainer, bound to the top level.
module mlpbp_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("new transaction taken while an item is in flight");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_bad_load_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("bad load result carries data");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind mlp_online_backprop_step_top mlpbp_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
